@@ rtl/core/djc_pkg.sv @@
package djc_pkg;

	localparam logic [1:0] OP_CLEAR   = 2'd0;
	localparam logic [1:0] OP_MEASURE = 2'd1;
	localparam logic [1:0] OP_COLOR   = 2'd2;

	// restoring divider: 2^32 + span - 1 needs 33 quotient bits
	localparam int QUO_BITS  = 33;
	localparam int DIV_STEPS = QUO_BITS;

	localparam int ONE_Q16 = 65536;

	localparam logic signed [18:0] X_HALF   = 19'sd32768;
	localparam logic signed [18:0] X_QUART  = 19'sd16384;
	localparam logic signed [18:0] X_3QUART = 19'sd49152;
	localparam logic signed [18:0] X_ONE    = 19'sd65536;

	typedef struct packed {
		logic load_item;
		logic range_clear;
		logic range_measure;
		logic div_init;
		logic div_step;
		logic div_last;
		logic mul;
		logic blend;
	} djc_cmd_t;

	typedef struct packed {
		logic need_div;
	} djc_stat_t;

	// jet trapezoid, Q16 in and out
	function automatic logic [16:0] trapezoid(input logic signed [18:0] x);
		logic signed [18:0] v;
		if (x <= -X_3QUART) begin
			v = '0;
		end else if (x <= -X_QUART) begin
			v = (x + X_3QUART) <<< 1;
		end else if (x <= X_QUART) begin
			v = X_ONE;
		end else if (x <= X_3QUART) begin
			v = (X_3QUART - x) <<< 1;
		end else begin
			v = '0;
		end
		return v[16:0];
	endfunction

	// floor((base*255 + colour*2^16) / 2^17)
	function automatic logic [7:0] blend(input logic [16:0] base, input logic [7:0] colour);
		logic [24:0] b;
		logic [24:0] s;
		b = {8'b0, base};
		s = (b << 8) - b + {1'b0, colour, 16'b0};
		return s[24:17];
	endfunction

endpackage

@@ rtl/core/djc_ctrl.sv @@
module djc_ctrl
	import djc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic [1:0] op,
	input  djc_stat_t stat,
	output djc_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DIV   = 2'd1;
	localparam logic [1:0] ST_MUL   = 2'd2;
	localparam logic [1:0] ST_BLEND = 2'd3;

	localparam int CntW = $clog2(DIV_STEPS);

	logic [1:0]      state_q, state_d;
	logic [CntW-1:0] cnt_q;
	logic            done_q;
	logic            div_last;

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign div_last = (cnt_q == CntW'(DIV_STEPS - 1));

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (op)
						OP_CLEAR:   cmd.range_clear = 1'b1;
						OP_MEASURE: cmd.range_measure = 1'b1;
						OP_COLOR: begin
							cmd.load_item = 1'b1;
							if (stat.need_div) begin
								cmd.div_init = 1'b1;
								state_d      = ST_DIV;
							end else begin
								state_d = ST_MUL;
							end
						end
						default: ;
					endcase
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (div_last) begin
					cmd.div_last = 1'b1;
					state_d      = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_BLEND;
			end
			ST_BLEND: begin
				cmd.blend = 1'b1;
				state_d   = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.blend;
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + CntW'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	a_done_after_blend: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_BLEND)
		else $error("result strobe without a blend step");

	a_div_exits_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |=> state_q == ST_DIV || state_q == ST_MUL)
		else $error("divider left to the wrong state");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_DIV) |-> cnt_q == '0)
		else $error("divider step count not cleared on entry");

endmodule

@@ rtl/core/djc_dp.sv @@
module djc_dp
	import djc_pkg::*;
#(
	parameter int DEPTH_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  djc_cmd_t              cmd,
	output djc_stat_t             stat,
	input  logic [DEPTH_BITS-1:0] depth,
	input  logic [7:0]            red,
	input  logic [7:0]            green,
	input  logic [7:0]            blue,
	output logic [7:0]            chan_zero,
	output logic [7:0]            chan_one,
	output logic [7:0]            chan_two,
	output logic                  depth_valid,
	output logic                  range_flat
);

	localparam int PW = DEPTH_BITS + 32;
	localparam int TW = DEPTH_BITS + 16;

	logic [DEPTH_BITS-1:0] range_min_q, range_max_q;
	logic [31:0]           recip_q;
	logic                  recip_ready_q;

	logic [DEPTH_BITS-1:0] diff_q;
	logic [7:0]            red_q, green_q, blue_q;
	logic                  valid_q, flat_q;

	logic [DEPTH_BITS-1:0] rem_q;
	logic [QUO_BITS-1:0]   num_q;
	logic [PW-1:0]         prod_q;

	logic [7:0] chan_zero_q, chan_one_q, chan_two_q;
	logic       depth_valid_q, range_flat_q;

	logic                  flat_now;
	logic [DEPTH_BITS-1:0] span;
	logic [DEPTH_BITS:0]   trial;
	logic                  ge;
	logic [QUO_BITS-1:0]   quo_next;
	logic [16:0]           t;
	logic signed [18:0]    ts;

	assign flat_now      = (range_max_q <= range_min_q);
	assign stat.need_div = (depth != '0) && !flat_now && !recip_ready_q;
	assign span          = range_max_q - range_min_q;

	assign trial    = {rem_q, num_q[QUO_BITS-1]};
	assign ge       = (trial >= {1'b0, span});
	assign quo_next = {num_q[QUO_BITS-2:0], ge};

	assign t  = (prod_q[PW-1:16] > TW'(ONE_Q16)) ? 17'h10000 : prod_q[32:16];
	assign ts = $signed({2'b00, t});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q   <= '1;
			range_max_q   <= '0;
			recip_q       <= '0;
			recip_ready_q <= 1'b0;
		end else begin
			if (cmd.range_clear) begin
				range_min_q   <= '1;
				range_max_q   <= '0;
				recip_ready_q <= 1'b0;
			end
			if (cmd.range_measure && depth != '0) begin
				if (depth < range_min_q) begin
					range_min_q   <= depth;
					recip_ready_q <= 1'b0;
				end
				if (depth > range_max_q) begin
					range_max_q   <= depth;
					recip_ready_q <= 1'b0;
				end
			end
			if (cmd.div_last) begin
				recip_q       <= quo_next[QUO_BITS-1] ? '1 : quo_next[31:0];
				recip_ready_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			diff_q  <= (depth <= range_min_q) ? '0 : depth - range_min_q;
			red_q   <= red;
			green_q <= green;
			blue_q  <= blue;
			valid_q <= (depth != '0);
			flat_q  <= flat_now;
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			num_q <= {1'b1, 32'b0} + QUO_BITS'(span) - QUO_BITS'(1);
		end else if (cmd.div_step) begin
			rem_q <= ge ? DEPTH_BITS'(trial - {1'b0, span}) : trial[DEPTH_BITS-1:0];
			num_q <= quo_next;
		end
		if (cmd.mul) begin
			prod_q <= PW'(diff_q) * PW'(recip_q);
		end
		if (cmd.blend) begin
			depth_valid_q <= valid_q;
			range_flat_q  <= flat_q;
			if (valid_q && !flat_q) begin
				chan_zero_q <= blend(trapezoid(ts - X_HALF), red_q);
				chan_one_q  <= blend(trapezoid(ts), green_q);
				chan_two_q  <= blend(trapezoid(ts + X_HALF), blue_q);
			end else begin
				chan_zero_q <= '0;
				chan_one_q  <= '0;
				chan_two_q  <= '0;
			end
		end
	end

	assign chan_zero   = chan_zero_q;
	assign chan_one    = chan_one_q;
	assign chan_two    = chan_two_q;
	assign depth_valid = depth_valid_q;
	assign range_flat  = range_flat_q;

	a_ready_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_last |=> recip_ready_q)
		else $error("reciprocal not marked ready after division");

	a_ready_needs_span: assert property (@(posedge clk) disable iff (!arst_n)
		recip_ready_q |-> range_max_q > range_min_q)
		else $error("reciprocal ready on a flat range");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.range_clear |=> range_max_q == '0 && !recip_ready_q)
		else $error("range clear did not take effect");

endmodule

@@ rtl/core/depth_jet_colorize_blend.sv @@
// Depth jet colorizer. A transaction is taken when start is high and busy is
// low. Op 0 (clear) and op 1 (measure) finish in the accepting cycle and leave
// busy low, so they stream at one per clock. Op 2 (colorize) raises busy for
// its multiply step, then its trapezoid and blend step, and puts its result on
// the channel ports with done high for exactly one cycle; it can be followed
// by the next transaction in that same cycle, but a new pixel is not taken
// while the last one is still in flight. The first op 2 with a nonzero depth
// on a non-flat range after the range has been cleared or has changed also
// recomputes the range reciprocal in a restoring divider that retires one
// quotient bit per clock, with busy high. The receiver cannot stall: done is a
// strobe and the result must be taken in that cycle. Ops 0, 1 and 3 produce no result.
module depth_jet_colorize_blend
	import djc_pkg::*;
#(
	parameter int DEPTH_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            op,
	input  logic [DEPTH_BITS-1:0] depth,
	input  logic [7:0]            red,
	input  logic [7:0]            green,
	input  logic [7:0]            blue,
	output logic                  done,
	output logic [7:0]            chan_zero,
	output logic [7:0]            chan_one,
	output logic [7:0]            chan_two,
	output logic                  depth_valid,
	output logic                  range_flat
);

	djc_cmd_t  cmd;
	djc_stat_t stat;

	djc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	djc_dp #(
		.DEPTH_BITS (DEPTH_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.depth       (depth),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.chan_zero   (chan_zero),
		.chan_one    (chan_one),
		.chan_two    (chan_two),
		.depth_valid (depth_valid),
		.range_flat  (range_flat)
	);

endmodule

@@ bench/depth_jet_colorize_blend_tb.sv @@
module depth_jet_colorize_blend_tb;
	import djc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH_W = 16;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 750;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 60;

	// fixed-point constants of the jet curve, Q16
	localparam longint Q_ONE   = 65536;
	localparam longint Q_HALF  = 32768;
	localparam longint Q_QTR   = 16384;
	localparam longint Q_3QTR  = 49152;

	typedef struct {
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
		logic       valid;
		logic       flat;
	} pixel_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [1:0]         op = OP_CLEAR;
	logic [DEPTH_W-1:0] depth = '0;
	logic [7:0]         red = '0;
	logic [7:0]         green = '0;
	logic [7:0]         blue = '0;
	logic               busy;
	logic               done;
	logic [7:0]         chan_zero;
	logic [7:0]         chan_one;
	logic [7:0]         chan_two;
	logic               depth_valid;
	logic               range_flat;

	// predictor state
	logic [15:0] range_lo = 16'hFFFF;
	logic [15:0] range_hi = 16'h0000;
	logic [31:0] recip_q = '0;
	bit          recip_ok = 1'b0;

	pixel_result_t expected_pixels[$];
	int error_count = 0;
	int cycle_count = 0;
	bit no_gaps = 1'b0;

	depth_jet_colorize_blend #(
		.DEPTH_BITS(DEPTH_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.depth(depth),
		.red(red),
		.green(green),
		.blue(blue),
		.done(done),
		.chan_zero(chan_zero),
		.chan_one(chan_one),
		.chan_two(chan_two),
		.depth_valid(depth_valid),
		.range_flat(range_flat)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic longint jet_base(input longint xv);
		if (xv <= -Q_3QTR) return 0;
		if (xv <= -Q_QTR) return 2 * (xv + Q_3QTR);
		if (xv <= Q_QTR) return Q_ONE;
		if (xv <= Q_3QTR) return 2 * (Q_3QTR - xv);
		return 0;
	endfunction

	function automatic logic [7:0] blend_chan(input longint b, input logic [7:0] c);
		longint unsigned s;
		s = longint'(b) * 255 + (longint'(c) << 16);
		return s[24:17];
	endfunction

	function automatic void colorize_predict(input logic [1:0] opc, input logic [15:0] d,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			output bit has_res, output pixel_result_t px);
		bit flat;
		bit valid;
		longint unsigned span;
		longint unsigned quo;
		longint unsigned diff;
		longint unsigned t;
		has_res = 1'b0;
		px = '{c0: '0, c1: '0, c2: '0, valid: 1'b0, flat: 1'b0};
		case (opc)
			OP_CLEAR: begin
				range_lo = 16'hFFFF;
				range_hi = 16'h0000;
				recip_ok = 1'b0;
			end
			OP_MEASURE: begin
				if (d != 0) begin
					if (d < range_lo) begin
						range_lo = d;
						recip_ok = 1'b0;
					end
					if (d > range_hi) begin
						range_hi = d;
						recip_ok = 1'b0;
					end
				end
			end
			OP_COLOR: begin
				has_res = 1'b1;
				flat = range_hi <= range_lo;
				valid = d != 0;
				if (valid && !flat) begin
					if (!recip_ok) begin
						span = range_hi - range_lo;
						quo = ((64'd1 << 32) + span - 1) / span;
						if (quo > 64'hFFFF_FFFF) quo = 64'hFFFF_FFFF;
						recip_q = quo[31:0];
						recip_ok = 1'b1;
					end
					diff = (d <= range_lo) ? 0 : longint'(d - range_lo);
					t = (diff * longint'(recip_q)) >> 16;
					if (t > Q_ONE) t = Q_ONE;
					px.c0 = blend_chan(jet_base(longint'(t) - Q_HALF), r);
					px.c1 = blend_chan(jet_base(longint'(t)), g);
					px.c2 = blend_chan(jet_base(longint'(t) + Q_HALF), b);
				end
				px.valid = valid;
				px.flat = flat;
			end
			default: ;
		endcase
	endfunction

	// drive one transaction and hold it until the block takes it
	task automatic send_item(input logic [1:0] opc, input logic [15:0] d,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		bit has_res;
		pixel_result_t px;
		start <= 1'b1;
		op <= opc;
		depth <= d;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (busy);
		colorize_predict(opc, d, r, g, b, has_res, px);
		if (has_res) expected_pixels.push_back(px);
	endtask

	task automatic idle_gap();
		int n;
		int pick;
		pick = $urandom_range(0, 99);
		if (no_gaps || pick < 60) n = 0;
		else if (pick < 90) n = $urandom_range(1, 3);
		else n = $urandom_range(10, 40);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		pixel_result_t px;
		if (done) begin
			if (expected_pixels.size() == 0) begin
				$error("unexpected result: no transaction pending");
				error_count++;
			end else begin
				px = expected_pixels.pop_front();
				if (chan_zero !== px.c0) begin
					$error("chan_zero: expected %0d, actual %0d", px.c0, chan_zero);
					error_count++;
				end
				if (chan_one !== px.c1) begin
					$error("chan_one: expected %0d, actual %0d", px.c1, chan_one);
					error_count++;
				end
				if (chan_two !== px.c2) begin
					$error("chan_two: expected %0d, actual %0d", px.c2, chan_two);
					error_count++;
				end
				if (depth_valid !== px.valid) begin
					$error("depth_valid: expected %0d, actual %0d", px.valid, depth_valid);
					error_count++;
				end
				if (range_flat !== px.flat) begin
					$error("range_flat: expected %0d, actual %0d", px.flat, range_flat);
					error_count++;
				end
			end
		end
	end

	// nothing measured since reset: range is empty
	task automatic test_empty_range();
		send_item(OP_COLOR, 16'd0, 8'hFF, 8'hFF, 8'hFF);
		idle_gap();
		send_item(OP_COLOR, 16'd500, 8'hFF, 8'h00, 8'hFF);
		idle_gap();
	endtask

	// widest possible range, zero depth ignored on measure
	task automatic test_full_span();
		send_item(OP_MEASURE, 16'd0, 8'h00, 8'h00, 8'h00);
		send_item(OP_COLOR, 16'd1000, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_MEASURE, 16'd1, 8'h00, 8'h00, 8'h00);
		send_item(OP_MEASURE, 16'hFFFF, 8'h00, 8'h00, 8'h00);
		send_item(OP_COLOR, 16'd0, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_COLOR, 16'd1, 8'hFF, 8'h00, 8'hFF);
		send_item(OP_COLOR, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_COLOR, 16'h8000, 8'h00, 8'hFF, 8'h00);
		idle_gap();
	endtask

	// span of one saturates the reciprocal; also below and above the range
	task automatic test_unit_span();
		send_item(OP_CLEAR, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_MEASURE, 16'd100, 8'h12, 8'h34, 8'h56);
		send_item(OP_MEASURE, 16'd101, 8'h12, 8'h34, 8'h56);
		send_item(OP_COLOR, 16'd100, 8'h80, 8'h40, 8'h20);
		send_item(OP_COLOR, 16'd101, 8'h80, 8'h40, 8'h20);
		send_item(OP_COLOR, 16'd99, 8'h01, 8'hFE, 8'h7F);
		send_item(OP_COLOR, 16'd102, 8'h01, 8'hFE, 8'h7F);
		idle_gap();
	endtask

	task automatic test_flat_span();
		send_item(OP_CLEAR, 16'd0, 8'h00, 8'h00, 8'h00);
		send_item(OP_MEASURE, 16'd500, 8'h00, 8'h00, 8'h00);
		send_item(OP_MEASURE, 16'd500, 8'h00, 8'h00, 8'h00);
		send_item(OP_COLOR, 16'd500, 8'hFF, 8'hFF, 8'hFF);
		idle_gap();
	endtask

	// op 3 must leave the range alone
	task automatic test_unused_op();
		send_item(OP_MEASURE, 16'd2000, 8'h00, 8'h00, 8'h00);
		send_item(OP_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_COLOR, 16'd1200, 8'hAA, 8'h55, 8'hC3);
		idle_gap();
	endtask

	// frames: clear, measure pass, colorize pass; some noise and broken frames
	task automatic test_random_frames();
		int sent;
		int kind;
		int frame_len;
		int spread;
		logic [15:0] base;
		logic [15:0] dv;
		logic [15:0] px_depth[$];
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 9);
			frame_len = $urandom_range(1, 10);
			if (kind == 0) begin
				repeat (frame_len) begin
					send_item(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom),
						8'($urandom), 8'($urandom));
					idle_gap();
					sent++;
				end
			end else begin
				base = 16'($urandom);
				if (kind <= 3) spread = $urandom_range(0, 3);
				else if (kind <= 6) spread = $urandom_range(0, 2000);
				else spread = 65535;
				px_depth.delete();
				repeat (frame_len) begin
					if ($urandom_range(0, 9) == 0) dv = 16'd0;
					else if (spread == 65535) dv = 16'($urandom);
					else dv = base + 16'($urandom_range(0, spread));
					px_depth.push_back(dv);
				end
				// kind 9 keeps the old range, kind 8 colorizes without measuring
				if (kind != 9) begin
					send_item(OP_CLEAR, 16'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom));
					idle_gap();
					sent++;
				end
				if (kind != 8) begin
					foreach (px_depth[i]) begin
						send_item(OP_MEASURE, px_depth[i], 8'($urandom), 8'($urandom),
							8'($urandom));
						idle_gap();
						sent++;
					end
				end
				foreach (px_depth[i]) begin
					dv = ($urandom_range(0, 15) == 0) ? 16'($urandom) : px_depth[i];
					send_item(OP_COLOR, dv, 8'($urandom), 8'($urandom), 8'($urandom));
					idle_gap();
					sent++;
				end
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_range();
		test_full_span();
		test_unit_span();
		test_flat_span();
		test_unused_op();
		test_random_frames();
		start <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/djc_pkg.sv
rtl/core/djc_ctrl.sv
rtl/core/djc_dp.sv
rtl/core/depth_jet_colorize_blend.sv
bench/depth_jet_colorize_blend_tb.sv
